[sv/maf_pkg.sv]
`default_nettype none

package maf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 9;
   localparam int KIND_W   = 2;

   // What the back end must do with a queued item
   typedef enum logic [KIND_W-1:0] {
      KIND_PASS,
      KIND_FILL,
      KIND_AVERAGE
   } kind_type;

endpackage

`default_nettype wire

[sv/maf_ram.sv]
`default_nettype none

module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[sv/maf_front.sv]
`default_nettype none

module maf_front #(
   parameter int IDX_W   = 8,
   parameter int LEN_W   = 9,
   parameter int ENTRY_W = 26
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                restart,
   input  wire logic [LEN_W-1:0]                    eff_length,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                q_space,
   output logic                                     q_push,
   output logic [ENTRY_W-1:0]                       q_entry
);

   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             full_ff, full_in;
   logic [IDX_W-1:0] cur_pos;
   logic [LEN_W-1:0] inc;
   maf_pkg::kind_type kind;

   assign req_stall = !q_space;
   assign q_push    = req_valid && q_space;

   always_comb begin
      cur_pos = pos_ff;
      if (LEN_W'(pos_ff) >= eff_length) begin
         cur_pos = '0;
      end
      inc     = LEN_W'(cur_pos) + LEN_W'(1);
      pos_in  = pos_ff;
      full_in = full_ff;
      if (eff_length == '0) begin
         kind = maf_pkg::KIND_PASS;
      end else begin
         kind = full_ff ? maf_pkg::KIND_AVERAGE : maf_pkg::KIND_FILL;
         // wrap the ring; the first wrap ends the fill phase
         if (inc >= eff_length) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = IDX_W'(inc);
         end
      end
      q_entry = {kind, cur_pos, req_sample};
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff  <= '0;
         full_ff <= 1'b0;
      end else if (q_push) begin
         pos_ff  <= pos_in;
         full_ff <= full_in;
      end
   end

endmodule

`default_nettype wire

[sv/maf_queue.sv]
`default_nettype none

module maf_queue #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  space,
   input  wire logic             pop,
   output logic                  avail,
   output logic [WIDTH-1:0]      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign space = count_ff != CNT_W'(DEPTH);
   assign avail = count_ff != '0;
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/maf_back.sv]
`default_nettype none

module maf_back #(
   parameter int MAX_WINDOW = 256,
   parameter int IDX_W      = 8,
   parameter int LEN_W      = 9,
   parameter int SUM_W      = 24,
   parameter int ENTRY_W    = 26
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [LEN_W-1:0]              eff_length,
   input  wire logic                          q_avail,
   input  wire logic [ENTRY_W-1:0]            q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [maf_pkg::SAMPLE_W-1:0]       rsp_filtered
);

   localparam int SW    = maf_pkg::SAMPLE_W;
   localparam int CNT_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SW-1:0]    cur_sample_ff;
   logic [IDX_W-1:0]        cur_pos_ff;
   logic [SW-1:0]           result_ff;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic [SW-1:0]           rsp_filtered_ff;

   maf_pkg::kind_type       head_kind;
   logic [IDX_W-1:0]        head_pos;
   logic signed [SW-1:0]    head_sample;
   logic signed [SW-1:0]    old_sample;
   logic [SW-1:0]           ram_rd;
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [SW-1:0]           ram_wdata;
   logic signed [SUM_W-1:0] new_sum;
   logic [SUM_W-1:0]        new_mag;
   logic [LEN_W:0]          trial;
   logic [SUM_W-1:0]        quo_final;
   logic                    out_free;

   assign head_kind   = maf_pkg::kind_type'(q_head[ENTRY_W-1 -: maf_pkg::KIND_W]);
   assign head_pos    = q_head[SW +: IDX_W];
   assign head_sample = q_head[SW-1:0];
   assign old_sample  = ram_rd;

   assign q_pop     = (state_ff == ST_IDLE) && q_avail;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cur_pos_ff;
      ram_wdata = cur_sample_ff;
      if (q_pop && head_kind == maf_pkg::KIND_FILL) begin
         ram_we    = 1'b1;
         ram_waddr = head_pos;
         ram_wdata = head_sample;
      end else if (state_ff == ST_READ) begin
         ram_we = 1'b1;
      end
   end

   maf_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_pos),
      .rd_data (ram_rd)
   );

   always_comb begin
      // replace the oldest entry in the running sum
      new_sum = sum_ff + SUM_W'(cur_sample_ff) - SUM_W'(old_sample);
      new_mag = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
      // one restoring step of |sum| / length per cycle
      trial = {rem_ff, quo_ff[SUM_W-1]};
      if (trial >= {1'b0, eff_length}) begin
         rem_in = LEN_W'(trial - {1'b0, eff_length});
         quo_in = {quo_ff[SUM_W-2:0], 1'b1};
      end else begin
         rem_in = LEN_W'(trial);
         quo_in = {quo_ff[SUM_W-2:0], 1'b0};
      end
      quo_final = neg_ff ? SUM_W'(-quo_in) : quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the taken result; the done state reloads it itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (restart) begin
                  sum_ff <= '0;
               end else if (q_avail) begin
                  cur_sample_ff <= head_sample;
                  cur_pos_ff    <= head_pos;
                  result_ff     <= head_sample;
                  case (head_kind)
                     maf_pkg::KIND_FILL: begin
                        sum_ff   <= sum_ff + SUM_W'(head_sample);
                        state_ff <= ST_DONE;
                     end
                     maf_pkg::KIND_AVERAGE: begin
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               sum_ff   <= new_sum;
               neg_ff   <= new_sum[SUM_W-1];
               quo_ff   <= new_mag;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               quo_ff <= quo_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(SUM_W - 1)) begin
                  result_ff <= quo_final[SW-1:0];
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_filtered_ff <= result_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/moving_average_filter_top.sv]
`default_nettype none

// Boxcar moving average over the last window_length signed 16-bit samples,
// kept as a ring in block RAM with a running sum. window_length is written
// through csr_write_enable/csr_write_data; the user must write it only while
// the block is idle, which the block itself does not enforce. Each write
// restarts the fill phase, and values above MAX_WINDOW act as MAX_WINDOW.
// While the window fills, and when the length is zero, each item comes back
// unchanged. Once the window is full, an item goes through the bit-serial
// restoring divider that forms sum / length one quotient bit a cycle. A
// two-entry queue sits between the classifying front end and the arithmetic
// back end, and the result register lets a new item be taken while the
// previous result is stalled. The ring is not cleared after reset.
module moving_average_filter_top #(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [maf_pkg::CSR_W-1:0]           csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [maf_pkg::SAMPLE_W-1:0]      rsp_filtered
);

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int CMP_W   = (LEN_W > maf_pkg::CSR_W) ? LEN_W : maf_pkg::CSR_W;
   localparam int ENTRY_W = maf_pkg::KIND_W + IDX_W + maf_pkg::SAMPLE_W;

   logic [maf_pkg::CSR_W-1:0] window_length_ff;
   logic [CMP_W-1:0]          len_ext;
   logic [LEN_W-1:0]          eff_length;
   logic                      q_space, q_push, q_avail, q_pop;
   logic [ENTRY_W-1:0]        q_entry, q_head;
   logic [maf_pkg::SAMPLE_W-1:0] filtered;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   // saturate the length at the ring depth
   always_comb begin
      len_ext = CMP_W'(window_length_ff);
      if (len_ext > CMP_W'(MAX_WINDOW)) begin
         len_ext = CMP_W'(MAX_WINDOW);
      end
      eff_length = len_ext[LEN_W-1:0];
   end

   maf_front #(
      .IDX_W   (IDX_W),
      .LEN_W   (LEN_W),
      .ENTRY_W (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_enable),
      .eff_length (eff_length),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_space    (q_space),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   maf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .space     (q_space),
      .pop       (q_pop),
      .avail     (q_avail),
      .head      (q_head)
   );

   maf_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX_W      (IDX_W),
      .LEN_W      (LEN_W),
      .SUM_W      (SUM_W),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write_enable),
      .eff_length   (eff_length),
      .q_avail      (q_avail),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (filtered)
   );

   assign rsp_filtered = filtered;

endmodule

`default_nettype wire

[sim/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W    = maf_pkg::SAMPLE_W;
   localparam int CSR_W       = maf_pkg::CSR_W;
   localparam int MAX_WINDOW  = 256;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 300;
   localparam int PRINT_LIMIT = 100;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_W-1:0]           csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   wire logic                  req_stall;
   logic signed [SAMPLE_W-1:0] req_sample       = '0;
   wire logic                  rsp_valid;
   logic                       rsp_stall        = 1'b0;
   wire logic signed [SAMPLE_W-1:0] rsp_filtered;

   moving_average_filter_top #(.MAX_WINDOW(MAX_WINDOW)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered)
   );

   always #6 clock = ~clock;

   // Shadow state of the filter
   logic signed [SAMPLE_W-1:0] window_mem [MAX_WINDOW];
   int                         window_pos;
   int                         window_sum;
   bit                         window_full;
   logic [CSR_W-1:0]           window_len;

   logic signed [SAMPLE_W-1:0] expected_filtered [$];

   int  n_items   = 0;
   int  n_results = 0;
   int  n_configs = 0;
   int  n_fail    = 0;

   // Stimulus controls, written by the test sequence only
   bit  tx_gaps      = 1'b1;
   bit  rx_random    = 1'b1;
   int  hold_trigger = 0;

   function automatic void restart_window();
      window_pos  = 0;
      window_sum  = 0;
      window_full = 1'b0;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] predict_filtered(
      input logic signed [SAMPLE_W-1:0] s
   );
      int                         n;
      int                         oldest;
      logic signed [SAMPLE_W-1:0] result;
      n = (window_len > MAX_WINDOW) ? MAX_WINDOW : int'(window_len);
      result = s;
      if (n != 0) begin
         if (window_pos >= n) window_pos = 0;
         if (!window_full) begin
            window_mem[window_pos] = s;
            window_sum += s;
            window_pos++;
            if (window_pos >= n) begin
               window_pos  = 0;
               window_full = 1'b1;
            end
         end else begin
            oldest = window_mem[window_pos];
            window_sum += s - oldest;
            window_mem[window_pos] = s;
            window_pos++;
            if (window_pos >= n) window_pos = 0;
            result = window_sum / n;
         end
      end
      return result;
   endfunction

   // Track configuration writes and accepted items, and check every result
   always @(posedge clock) begin : monitor
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         window_len = '0;
         restart_window();
      end else begin
         if (csr_write_enable) begin
            window_len = csr_write_data;
            restart_window();
            n_configs++;
         end
         if (req_valid && !req_stall) begin
            expected_filtered.push_back(predict_filtered(req_sample));
            n_items++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_filtered.size() == 0) begin
               n_fail++;
               if (n_fail <= PRINT_LIMIT)
                  $display("%0t: result with nothing expected, actual %0d", $time, rsp_filtered);
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_filtered !== want) begin
                  n_fail++;
                  if (n_fail <= PRINT_LIMIT)
                     $display("%0t: filtered mismatch, expected %0d, actual %0d",
                              $time, want, rsp_filtered);
               end
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Result side: random stall runs, plus a long hold when one is triggered
   always @(posedge clock) begin : receiver
      int rx_left;
      int hold_left;
      int hold_seen;
      if (reset) begin
         rx_left   = 0;
         hold_left = 0;
         hold_seen = hold_trigger;
         rsp_stall <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_left > 0) begin
         rx_left--;
         rsp_stall <= 1'b1;
      end else if (rx_random) begin
         rx_left = pick_gap();
         if (rx_left > 0) begin
            rx_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Drop valid and hold until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_window(input logic [CSR_W-1:0] len);
      wait_drained();
      csr_write_data   <= len;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_pass_through();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
   endtask

   task automatic test_short_windows();
      set_window(9'd1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sd7);
      // negative sums must truncate toward zero
      set_window(9'd3);
      send_sample(-16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(-16'sd2);
      send_sample(16'sd5);
      set_window(9'd2);
      repeat (3) send_sample(16'sh8000);
      repeat (3) send_sample(16'sh7FFF);
      set_window(9'd0);
      send_sample(16'sh1234);
      send_sample(16'shFEDC);
   endtask

   task automatic test_max_window();
      // lengths above the ring size act as the ring size
      set_window(9'h1FF);
      repeat (MAX_WINDOW + 4) send_sample(16'sh8000);
      set_window(9'd256);
      repeat (MAX_WINDOW + 4) send_sample(16'sh7FFF);
   endtask

   task automatic test_back_pressure();
      set_window(9'd4);
      tx_gaps = 1'b0;
      hold_trigger <= hold_trigger + 1;
      repeat (30) send_sample(rand_sample());
      wait_drained();
      tx_gaps = 1'b1;
      repeat (20) send_sample(rand_sample());
   endtask

   task automatic test_random_windows();
      int sent;
      int len;
      int count;
      int large_left;
      sent = 0;
      large_left = 2;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = (large_left > 0) ? $urandom_range(200, 511) : $urandom_range(1, 8);
            2, 3:    len = $urandom_range(9, 40);
            default: len = $urandom_range(1, 8);
         endcase
         if (len > 8 && len >= 200) large_left--;
         set_window(CSR_W'(len));
         tx_gaps = ($urandom_range(0, 3) != 0);
         rx_random <= ($urandom_range(0, 3) != 0);
         count = ((len > MAX_WINDOW) ? MAX_WINDOW : len) + $urandom_range(5, 60);
         repeat (count) send_sample(rand_sample());
         sent += count;
      end
      tx_gaps = 1'b1;
      rx_random <= 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_pass_through();
      test_short_windows();
      test_back_pressure();
      test_max_window();
      test_random_windows();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_filtered.size() != 0) n_fail++;
      $display("Run covered %0d items and %0d results over %0d window settings,",
               n_items, n_results, n_configs);
      $display("including pass-through, saturated lengths, extreme means and long back-pressure.");
      if (n_fail == 0) begin
         $display("moving_average_filter_top verification clean");
      end else begin
         $display("moving_average_filter_top verification failed");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("Timed out with %0d results still expected", expected_filtered.size());
      $display("moving_average_filter_top verification failed");
      $finish;
   end

endmodule
